// ===== rtl/bsa_pkg.sv =====
// Shared types and constants of the bitmap slot allocator.
// Used by bsa_engine and bitmap_slot_allocator; no dependencies.
package bsa_pkg;

   // bitmap geometry
   localparam int MAP_BYTES = 512;
   localparam int BYTE_AW   = $clog2(MAP_BYTES);
   localparam int PTR_W     = BYTE_AW + 1;

   // field widths
   localparam int OP_W     = 2;
   localparam int INDEX_W  = 12;
   localparam int SLOT_W   = 12;
   localparam int START_W  = 9;
   localparam int END_W    = 10;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 10;

   // operation codes
   localparam logic [OP_W-1:0] OP_SET   = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_TEST  = 2'd2;
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_START = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_END   = 1'd1;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [INDEX_W-1:0] bit_index;
   } req_type;

   typedef struct packed {
      logic              bit_value;
      logic              found;
      logic [SLOT_W-1:0] slot;
   } rsp_type;

   // scan window, end already clamped to the map size
   typedef struct packed {
      logic [START_W-1:0] start_byte;
      logic [END_W-1:0]   end_byte;
   } scan_cfg_type;

   typedef struct packed {
      logic    valid;
      req_type item;
   } eng_cmd_type;

   typedef struct packed {
      logic ready;
      logic out_valid;
   } eng_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/bsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsa_ram #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 8,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/bsa_engine.sv =====
// Sequencer and byte scan unit of the bitmap allocator; owns the bitmap RAM.
// Depends on bsa_pkg and bsa_ram.
module bsa_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  bsa_pkg::eng_cmd_type   cmd,
   input  bsa_pkg::scan_cfg_type  cfg,
   input  logic                   out_ready,
   output bsa_pkg::eng_status_type status,
   output bsa_pkg::rsp_type       result
);

   bsa_pkg::state_type state_ff, state_in;
   logic [bsa_pkg::OP_W-1:0]    op_ff, op_in;
   logic [bsa_pkg::INDEX_W-1:0] idx_ff, idx_in;
   logic [bsa_pkg::PTR_W-1:0]   ptr_ff, ptr_in;
   logic                        chk_valid_ff, chk_valid_in;
   logic [bsa_pkg::BYTE_AW-1:0] chk_addr_ff, chk_addr_in;
   logic [bsa_pkg::BYTE_AW-1:0] clr_cnt_ff, clr_cnt_in;
   bsa_pkg::rsp_type            res_ff, res_in;

   logic                        ram_we;
   logic [bsa_pkg::BYTE_AW-1:0] ram_waddr;
   logic [7:0]                  ram_wdata;
   logic [bsa_pkg::BYTE_AW-1:0] ram_raddr;
   logic [7:0]                  ram_rdata;

   logic [2:0]                  first_k;
   logic [bsa_pkg::BYTE_AW-1:0] idx_byte;
   logic [2:0]                  idx_bit;
   logic                        idx_inside;
   logic                        issue;
   logic [bsa_pkg::BYTE_AW-1:0] rel_byte;

   bsa_ram #(
      .DEPTH (bsa_pkg::MAP_BYTES),
      .WIDTH (8),
      .AW    (bsa_pkg::BYTE_AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // lowest set bit of the byte just read
   always_comb begin
      first_k = '0;
      for (int k = 7; k >= 0; k--) begin
         if (ram_rdata[k]) begin
            first_k = 3'(k);
         end
      end
   end

   assign idx_byte   = idx_ff[bsa_pkg::INDEX_W-1:3];
   assign idx_bit    = idx_ff[2:0];
   assign idx_inside = {1'b0, idx_ff[bsa_pkg::INDEX_W-1:3]}
                       < (bsa_pkg::INDEX_W - 2)'(bsa_pkg::MAP_BYTES);
   assign issue      = ptr_ff < cfg.end_byte;
   assign rel_byte   = chk_addr_ff - cfg.start_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsa_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      ptr_ff      <= ptr_in;
      chk_addr_ff <= chk_addr_in;
      res_ff      <= res_in;
   end

   always_comb begin
      state_in         = state_ff;
      op_in            = op_ff;
      idx_in           = idx_ff;
      ptr_in           = ptr_ff;
      chk_valid_in     = 1'b0;
      chk_addr_in      = chk_addr_ff;
      clr_cnt_in       = clr_cnt_ff;
      res_in           = res_ff;
      ram_we           = 1'b0;
      ram_waddr        = chk_addr_ff;
      ram_wdata        = '0;
      ram_raddr        = ptr_ff[bsa_pkg::BYTE_AW-1:0];
      status.ready     = 1'b0;
      status.out_valid = 1'b0;

      unique case (state_ff)
         bsa_pkg::ST_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == bsa_pkg::BYTE_AW'(bsa_pkg::MAP_BYTES - 1)) begin
               state_in = bsa_pkg::ST_IDLE;
            end
         end

         bsa_pkg::ST_IDLE: begin
            status.ready = 1'b1;
            ram_raddr    = cmd.item.bit_index[bsa_pkg::INDEX_W-1:3];
            if (cmd.valid) begin
               op_in  = cmd.item.operation;
               idx_in = cmd.item.bit_index;
               if (cmd.item.operation == bsa_pkg::OP_ALLOC) begin
                  if ({1'b0, cfg.start_byte} >= cfg.end_byte) begin
                     // empty window: nothing to scan
                     res_in   = '{bit_value: 1'b0, found: 1'b0, slot: '0};
                     state_in = bsa_pkg::ST_DONE;
                  end else begin
                     ptr_in   = bsa_pkg::PTR_W'(cfg.start_byte);
                     state_in = bsa_pkg::ST_SCAN;
                  end
               end else begin
                  state_in = bsa_pkg::ST_ACCESS;
               end
            end
         end

         bsa_pkg::ST_ACCESS: begin
            ram_waddr = idx_byte;
            res_in    = '{bit_value: 1'b0, found: 1'b1, slot: '0};
            unique case (op_ff)
               bsa_pkg::OP_SET: begin
                  ram_we    = idx_inside;
                  ram_wdata = ram_rdata | (8'b1 << idx_bit);
               end
               bsa_pkg::OP_CLEAR: begin
                  ram_we    = idx_inside;
                  ram_wdata = ram_rdata & ~(8'b1 << idx_bit);
               end
               bsa_pkg::OP_TEST: begin
                  res_in.bit_value = idx_inside & ram_rdata[idx_bit];
               end
               default: begin
                  res_in.bit_value = 1'b0;
               end
            endcase
            state_in = bsa_pkg::ST_DONE;
         end

         bsa_pkg::ST_SCAN: begin
            // read one byte per cycle, check the byte read the cycle before
            if (chk_valid_ff && (ram_rdata != '0)) begin
               ram_we    = 1'b1;
               ram_waddr = chk_addr_ff;
               ram_wdata = ram_rdata & ~(8'b1 << first_k);
               res_in    = '{bit_value: 1'b0, found: 1'b1,
                             slot: {rel_byte, first_k}};
               state_in  = bsa_pkg::ST_DONE;
            end else if (!issue) begin
               res_in   = '{bit_value: 1'b0, found: 1'b0, slot: '0};
               state_in = bsa_pkg::ST_DONE;
            end else begin
               ptr_in       = ptr_ff + 1'b1;
               chk_valid_in = 1'b1;
               chk_addr_in  = ptr_ff[bsa_pkg::BYTE_AW-1:0];
            end
         end

         bsa_pkg::ST_DONE: begin
            status.out_valid = 1'b1;
            if (out_ready) begin
               state_in = bsa_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bsa_pkg::ST_CLEAR;
         end
      endcase
   end

   assign result = res_ff;

   // reset always starts the clearing pass
   a_reset_clears: assert property (@(posedge clock) reset |=> !status.ready)
      else $error("engine ready right after reset");

   a_write_when_busy: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff != bsa_pkg::ST_IDLE) && (state_ff != bsa_pkg::ST_DONE))
      else $error("bitmap written while idle or holding a result");

   a_slot_needs_found: assert property (@(posedge clock) disable iff (reset)
      status.out_valid && !result.found |-> result.slot == '0)
      else $error("nonzero slot without a found bit");

   a_value_only_test: assert property (@(posedge clock) disable iff (reset)
      status.out_valid && result.bit_value |-> op_ff == bsa_pkg::OP_TEST)
      else $error("bit value set for an operation other than test");

endmodule

// ===== rtl/bitmap_slot_allocator.sv =====
// Top level of the first-fit bitmap slot allocator: ports, scan window
// registers and the result register. Depends on bsa_pkg and bsa_engine.
// Mark and test go from accept through the access and done states into
//   the result register; allocate reads the window byte by byte until a
//   free bit turns up (at most the window length, 512 bytes); an empty
//   window goes straight to the done state. The engine holds one transaction
//   and takes the next once idle, even while a result still waits on rsp.
// Reset: synchronous; a clearing pass over every byte marks every bit used,
//   with req_stall high; csr writes are taken at all times.
module bitmap_slot_allocator (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bsa_pkg::req_type                    req_payload,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bsa_pkg::rsp_type                    rsp_payload,
   // configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bsa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bsa_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [bsa_pkg::START_W-1:0] start_ff, start_in;
   logic [bsa_pkg::END_W-1:0]   end_ff, end_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   bsa_pkg::rsp_type            rsp_ff, rsp_in;

   bsa_pkg::eng_cmd_type        cmd;
   bsa_pkg::scan_cfg_type       cfg;
   bsa_pkg::eng_status_type     status;
   bsa_pkg::rsp_type            eng_result;
   logic                        out_ready;
   logic                        csr_write;

   // configuration registers: always writable
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      if (csr_write) begin
         unique case (csr_index)
            bsa_pkg::CSR_SCAN_START: start_in = csr_wdata[bsa_pkg::START_W-1:0];
            bsa_pkg::CSR_SCAN_END:   end_in   = csr_wdata[bsa_pkg::END_W-1:0];
            default:                 start_in = start_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         end_ff   <= bsa_pkg::END_W'(bsa_pkg::MAP_BYTES);
      end else begin
         start_ff <= start_in;
         end_ff   <= end_in;
      end
   end

   // clamp the window end to the map size
   assign cfg.start_byte = start_ff;
   assign cfg.end_byte   = (end_ff > bsa_pkg::END_W'(bsa_pkg::MAP_BYTES))
                           ? bsa_pkg::END_W'(bsa_pkg::MAP_BYTES) : end_ff;

   // request side: accept only while the engine sits idle
   assign req_stall = !status.ready;
   assign cmd.valid = req_valid & status.ready;
   assign cmd.item  = req_payload;

   bsa_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg),
      .out_ready (out_ready),
      .status    (status),
      .result    (eng_result)
   );

   // result register: load when empty or being drained
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_ready) begin
         rsp_valid_in = status.out_valid;
         if (status.out_valid) begin
            rsp_in = eng_result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_slot_allocator: directed table, then random phases.
// Depends on bsa_pkg and the allocator RTL; checks each response against its own bitmap copy or a hand-typed row.
module tb_top;
   import bsa_pkg::*;

   // Directed stimulus row: either a scan window write or one request,
   // optionally with a hand-typed response.
   typedef struct packed {
      logic                  is_csr;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_val;
      req_type               item;
      logic                  typed;
      rsp_type               want;
   } plan_row_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   // Shadow of the free-space bitmap and the scan window (1 = free).
   logic [7:0]         free_bits [MAP_BYTES];
   logic [START_W-1:0] win_start;
   logic [END_W-1:0]   win_end;

   rsp_type      pending_results [$];
   plan_row_type directed_plan [$];

   int unsigned mismatch_count;
   int unsigned results_seen;
   int unsigned op_count [4];
   int unsigned allocs_hit;
   int unsigned allocs_missed;
   int unsigned window_writes;
   bit          calm_stretch;

   bitmap_slot_allocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run: every allocate scanning the
   // full map plus stalls and gaps, several times over.
   initial begin
      #50_000_000;
      $display("timeout with %0d responses outstanding", pending_results.size());
      $display("tb_top failed");
      $finish;
   end

   // Apply one request to the shadow bitmap and return the response it must
   // produce. Allocate walks the window byte by byte, lowest bit first, and
   // reports the slot relative to the first bit of the window.
   function automatic rsp_type predict_bitmap_op(input req_type item);
      rsp_type     res;
      int unsigned byte_no;
      int unsigned bit_no;
      int unsigned last;
      int unsigned b;
      int unsigned k;
      bit          hit;
      res       = '0;
      res.found = 1'b1;
      byte_no   = item.bit_index >> 3;
      bit_no    = item.bit_index & 7;
      case (item.operation)
         OP_SET: begin
            if (byte_no < MAP_BYTES) free_bits[byte_no][bit_no] = 1'b1;
         end
         OP_CLEAR: begin
            if (byte_no < MAP_BYTES) free_bits[byte_no][bit_no] = 1'b0;
         end
         OP_TEST: begin
            if (byte_no < MAP_BYTES) res.bit_value = free_bits[byte_no][bit_no];
         end
         default: begin
            // clamp the end of the window to the map; empty window finds nothing
            last      = (win_end > MAP_BYTES) ? MAP_BYTES : win_end;
            res.found = 1'b0;
            hit       = 1'b0;
            for (b = win_start; b < last && !hit; b++) begin
               for (k = 0; k < 8 && !hit; k++) begin
                  if (free_bits[b][k]) begin
                     free_bits[b][k] = 1'b0;
                     res.found       = 1'b1;
                     res.slot        = SLOT_W'((b - win_start) * 8 + k);
                     hit             = 1'b1;
                  end
               end
            end
         end
      endcase
      return res;
   endfunction

   function automatic void plan_op(input logic [OP_W-1:0] op, input int unsigned idx);
      plan_row_type row;
      row                = '0;
      row.item.operation = op;
      row.item.bit_index = INDEX_W'(idx);
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_checked(input logic [OP_W-1:0] op, input int unsigned idx,
                                        input logic bv, input logic fnd,
                                        input int unsigned slt);
      plan_row_type row;
      row                = '0;
      row.item.operation = op;
      row.item.bit_index = INDEX_W'(idx);
      row.typed          = 1'b1;
      row.want.bit_value = bv;
      row.want.found     = fnd;
      row.want.slot      = SLOT_W'(slt);
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_window(input logic [CSR_IDX_W-1:0] idx,
                                       input int unsigned val);
      plan_row_type row;
      row         = '0;
      row.is_csr  = 1'b1;
      row.csr_idx = idx;
      row.csr_val = CSR_DATA_W'(val);
      directed_plan.push_back(row);
   endfunction

   function automatic void flag_mismatch(input string what, input int unsigned want,
                                         input int unsigned got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
   endfunction

   // Offer one request and hold it until the allocator takes it, then
   // predict its response and maybe idle the request channel for a while.
   task automatic drive_request(input req_type item, input logic typed, input rsp_type want);
      rsp_type predicted;
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      predicted = predict_bitmap_op(item);
      pending_results.push_back(typed ? want : predicted);
      op_count[item.operation]++;
      if (item.operation == OP_ALLOC) begin
         if (predicted.found) allocs_hit++;
         else allocs_missed++;
      end
      if (!calm_stretch && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(8, 1)) @(posedge clock);
      end
   endtask

   // Drop the request valid and wait until every response is back; each
   // request makes exactly one response, so the engine is idle after that.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write one scan window register while the allocator is idle.
   task automatic write_scan_reg(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      wait_until_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SCAN_START) win_start = val[START_W-1:0];
      else win_end = val[END_W-1:0];
      window_writes++;
   endtask

   // Response checker: compare each accepted response with the oldest
   // prediction, field by field.
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            flag_mismatch("unexpected response, slot", 0, rsp_payload.slot);
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.bit_value !== want.bit_value)
               flag_mismatch("bit_value", want.bit_value, rsp_payload.bit_value);
            if (rsp_payload.found !== want.found)
               flag_mismatch("found", want.found, rsp_payload.found);
            if (rsp_payload.slot !== want.slot)
               flag_mismatch("slot", want.slot, rsp_payload.slot);
         end
      end
   end

   // Response stall: random back-pressure, none during the calm stretch, and
   // one long hold-off once 700 responses are through so the
   // allocator backs up and stalls its request side.
   initial begin : result_sink
      bit          holdoff_done;
      int unsigned holdoff_left;
      holdoff_done = 1'b0;
      holdoff_left = 0;
      forever begin
         @(posedge clock);
         if (!holdoff_done && results_seen >= 700) begin
            holdoff_done = 1'b1;
            holdoff_left = 300;
         end
         if (holdoff_left != 0) begin
            rsp_stall <= 1'b1;
            holdoff_left--;
         end else begin
            rsp_stall <= !calm_stretch && ($urandom_range(99) < 35);
         end
      end
   end

   initial begin : stimulus
      plan_row_type       row;
      req_type            item;
      logic [START_W-1:0] s;
      logic [END_W-1:0]   e;
      int unsigned        phase;
      int unsigned        n;
      int unsigned        clamped;
      int unsigned        base;
      int unsigned        span;
      int unsigned        pick;

      foreach (free_bits[i]) free_bits[i] = 8'h00;
      win_start      = '0;
      win_end        = END_W'(512);
      mismatch_count = 0;
      results_seen   = 0;
      allocs_hit     = 0;
      allocs_missed  = 0;
      window_writes  = 0;
      calm_stretch   = 1'b0;
      foreach (op_count[i]) op_count[i] = 0;

      // Directed table. Out of reset every bit is used and the window is the
      // whole map, so the first rows can be typed in directly.
      plan_checked(OP_TEST, 0, 1'b0, 1'b1, 0);
      plan_checked(OP_TEST, 4095, 1'b0, 1'b1, 0);
      plan_checked(OP_ALLOC, 0, 1'b0, 1'b0, 0);      // nothing free after reset
      plan_checked(OP_SET, 0, 1'b0, 1'b1, 0);
      plan_checked(OP_TEST, 0, 1'b1, 1'b1, 0);
      plan_checked(OP_ALLOC, 0, 1'b0, 1'b1, 0);
      plan_checked(OP_SET, 4095, 1'b0, 1'b1, 0);
      plan_checked(OP_ALLOC, 0, 1'b0, 1'b1, 4095);   // last bit of the map, full scan
      plan_op(OP_SET, 7);
      plan_op(OP_SET, 8);
      plan_op(OP_CLEAR, 7);
      plan_checked(OP_TEST, 7, 1'b0, 1'b1, 0);
      plan_checked(OP_ALLOC, 0, 1'b0, 1'b1, 8);      // crosses a byte boundary
      plan_op(OP_SET, 12'hAAA);
      plan_op(OP_SET, 12'h555);
      plan_op(OP_TEST, 12'hAAA);
      // last byte only, end past the map is clamped
      plan_window(CSR_SCAN_START, 511);
      plan_window(CSR_SCAN_END, 1023);
      plan_op(OP_SET, 4088);
      plan_checked(OP_ALLOC, 0, 1'b0, 1'b1, 0);
      plan_checked(OP_ALLOC, 0, 1'b0, 1'b0, 0);
      // start past end: empty window never allocates
      plan_window(CSR_SCAN_START, 300);
      plan_window(CSR_SCAN_END, 200);
      plan_op(OP_SET, 2400);
      plan_checked(OP_ALLOC, 0, 1'b0, 1'b0, 0);
      plan_window(CSR_SCAN_START, 0);
      plan_window(CSR_SCAN_END, 0);
      plan_checked(OP_ALLOC, 0, 1'b0, 1'b0, 0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if (row.is_csr) write_scan_reg(row.csr_idx, row.csr_val);
         else drive_request(row.item, row.typed, row.want);
      end

      // Random phases, each under its own scan window. Most windows are 1 to 16
      // bytes wide so allocate stays cheap; two cover the whole map, one is
      // random, one is empty and one sits on the last byte.
      for (phase = 0; phase < 12; phase++) begin
         case (phase)
            0: begin
               s = '0;
               e = END_W'(512);
            end
            3: begin
               s = START_W'($urandom_range(511));
               e = END_W'($urandom_range(1023));
            end
            6: begin
               s = START_W'($urandom_range(511, 1));
               e = END_W'($urandom_range(s - 1));
            end
            9: begin
               s = START_W'(511);
               e = END_W'(1023);
            end
            11: begin
               s = '0;
               e = END_W'(1023);
            end
            default: begin
               s = START_W'($urandom_range(511));
               e = END_W'(s) + END_W'($urandom_range(16, 1));
            end
         endcase
         write_scan_reg(CSR_SCAN_START, CSR_DATA_W'(s));
         write_scan_reg(CSR_SCAN_END, CSR_DATA_W'(e));
         calm_stretch = (phase == 4);

         clamped = (e > MAP_BYTES) ? MAP_BYTES : e;
         base    = s * 8;
         span    = (clamped > s) ? (clamped - s) * 8 : 64;
         for (n = 0; n < 128; n++) begin
            pick = $urandom_range(99);
            if (pick < 35) item.operation = OP_SET;
            else if (pick < 45) item.operation = OP_CLEAR;
            else if (pick < 65) item.operation = OP_TEST;
            else item.operation = OP_ALLOC;
            // mostly aim at the window, sometimes anywhere in the index range
            if ($urandom_range(99) < 15 || base + span > 4096)
               item.bit_index = INDEX_W'($urandom_range(4095));
            else
               item.bit_index = INDEX_W'(base + $urandom_range(span - 1));
            drive_request(item, 1'b0, '0);
         end
      end
      calm_stretch = 1'b0;

      wait_until_idle();
      repeat (20) @(posedge clock);
      $display("ran %0d set, %0d clear, %0d test, %0d allocate (%0d taken, %0d none free)",
               op_count[OP_SET], op_count[OP_CLEAR], op_count[OP_TEST],
               op_count[OP_ALLOC], allocs_hit, allocs_missed);
      $display("%0d window register writes, %0d responses checked, %0d mismatches",
               window_writes, results_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
